// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define WLRU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define WLRU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/wlru_pkg.sv -----
// shared constants, payload types and controller/datapath structs
package wlru_pkg;

	localparam int KEY_W        = 32;
	localparam int WEIGHT_W     = 25;
	localparam int STAMP_W      = 32;
	localparam int SETTING_W    = 10;
	localparam int BUDGET_W     = 27;
	localparam int TOTAL_OUT_W  = 28;
	localparam int COUNT_OUT_W  = 5;
	localparam int WLRU_ENTRIES = 16;

	localparam logic [BUDGET_W-1:0] BUDGET_UNIT        = 27'd100000;
	localparam logic [BUDGET_W-1:0] DEFAULT_BUDGET_RST = 27'd2000000;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 27;
	localparam logic [CFG_IDX_W-1:0] REG_BUDGET_SETTING = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_BUDGET = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [WEIGHT_W-1:0] weight;
	} req_item_t;

	typedef struct packed {
		logic                   is_eviction;
		logic [KEY_W-1:0]       evicted_key;
		logic                   hit;
		logic [TOTAL_OUT_W-1:0] total_weight;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic                   last;
	} rsp_item_t;

	typedef struct packed {
		logic load;       // latch request, restart lookup scan
		logic look;       // lookup scan running
		logic start_old;  // restart oldest-entry scan
		logic old;        // oldest-entry scan running
		logic hit_wr;     // refresh stamp of hit slot, send final result
		logic evict;      // drop oldest slot, send eviction result
		logic insert;     // fill free slot, send final result
	} ctrl_cmd_t;

	typedef struct packed {
		logic match;
		logic scan_done;
		logic over_budget;
		logic empty;
		logic full;
		logic out_free;
	} ctrl_sts_t;

endpackage

// ----- hw/rtl/wlru_ifs.sv -----
// request and response channel interfaces
interface wlru_req_if import wlru_pkg::*; ();
	logic      valid;
	logic      ready;
	req_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface wlru_rsp_if import wlru_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// ----- hw/rtl/wlru_ram.sv -----
// generic single-write, single-read ram with registered read data
module wlru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/wlru_ctrl.sv -----
// access sequencer: lookup, budget and full-table evictions, insert
module wlru_ctrl import wlru_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  ctrl_sts_t  sts,
	output ctrl_cmd_t  cmd
);
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOOK   = 3'd1;
	localparam logic [2:0] ST_HIT    = 3'd2;
	localparam logic [2:0] ST_CHECK  = 3'd3;
	localparam logic [2:0] ST_SCAN   = 3'd4;
	localparam logic [2:0] ST_EVICT  = 3'd5;
	localparam logic [2:0] ST_INSERT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				if (sts.match) begin
					state_nxt = ST_HIT;
				end else if (sts.scan_done) begin
					state_nxt = ST_CHECK;
				end
			end
			ST_HIT: begin
				if (sts.out_free) begin
					cmd.hit_wr = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			ST_CHECK: begin
				if ((sts.over_budget && !sts.empty) || sts.full) begin
					cmd.start_old = 1'b1;
					state_nxt     = ST_SCAN;
				end else begin
					state_nxt = ST_INSERT;
				end
			end
			ST_SCAN: begin
				cmd.old = 1'b1;
				if (sts.scan_done) begin
					state_nxt = ST_EVICT;
				end
			end
			ST_EVICT: begin
				if (sts.out_free) begin
					cmd.evict = 1'b1;
					state_nxt = ST_CHECK;
				end
			end
			ST_INSERT: begin
				if (sts.out_free) begin
					cmd.insert = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end
endmodule

// ----- hw/rtl/wlru_dp.sv -----
// datapath: slot table, scan pipeline, totals, config and result register
module wlru_dp import wlru_pkg::*; #(
	parameter int ENTRIES = WLRU_ENTRIES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  req_item_t             req_item,
	output logic                  rsp_valid,
	output rsp_item_t             rsp_item,
	input  logic                  rsp_ready,
	input  ctrl_cmd_t             cmd,
	output ctrl_sts_t             sts
);
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int TOTAL_W = WEIGHT_W + IDX_W + 3;
	localparam int WORD_W  = KEY_W + WEIGHT_W + STAMP_W;
	localparam int EXT_W   = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;

	// configuration
	logic [SETTING_W-1:0] setting_q;
	logic [BUDGET_W-1:0]  default_q;
	logic [BUDGET_W-1:0]  budget_q;
	logic [BUDGET_W-1:0]  budget_prod;

	// request
	logic [KEY_W-1:0]    key_q;
	logic [WEIGHT_W-1:0] weight_q;

	// scan pipeline
	logic [IDX_W:0]   scan_cnt_q;
	logic             issue;
	logic             v_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             slot_vld;

	// ram
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] rd_word;
	logic [KEY_W-1:0]    rd_key;
	logic [WEIGHT_W-1:0] rd_wt;
	logic [STAMP_W-1:0]  rd_stamp;

	// slot tracking
	logic [ENTRIES-1:0]  valid_q;
	logic [IDX_W-1:0]    free_q;
	logic                free_found_q;
	logic [IDX_W-1:0]    hit_slot_q;
	logic [WEIGHT_W-1:0] hit_wt_q;
	logic [IDX_W-1:0]    best_q;
	logic                best_found_q;
	logic [STAMP_W-1:0]  best_stamp_q;
	logic [KEY_W-1:0]    best_key_q;
	logic [WEIGHT_W-1:0] best_wt_q;

	// totals
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W-1:0] total_nxt;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_nxt;
	logic [EXT_W-1:0]   count_ext;
	logic [STAMP_W-1:0] clock_q;

	logic      emit;
	logic      out_free;
	rsp_item_t rsp_item_q;
	logic      rsp_valid_q;

	assign budget_prod = BUDGET_W'(setting_q) * BUDGET_UNIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setting_q <= '0;
			default_q <= DEFAULT_BUDGET_RST;
			budget_q  <= DEFAULT_BUDGET_RST;
		end else begin
			budget_q <= (setting_q != '0) ? budget_prod : default_q;
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_BUDGET_SETTING: setting_q <= cfg_wdata[SETTING_W-1:0];
					REG_DEFAULT_BUDGET: default_q <= cfg_wdata[BUDGET_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q    <= req_item.key;
			weight_q <= req_item.weight;
		end
	end

	// scan address counter, one slot per cycle
	assign issue = (cmd.look || cmd.old) && (scan_cnt_q < (IDX_W + 1)'(ENTRIES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
			v_s1       <= 1'b0;
		end else begin
			v_s1 <= issue;
			if (cmd.load || cmd.start_old) begin
				scan_cnt_q <= '0;
			end else if (issue) begin
				scan_cnt_q <= scan_cnt_q + (IDX_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_cnt_q[IDX_W-1:0];
	end

	assign ram_we    = cmd.hit_wr || cmd.insert;
	assign ram_waddr = cmd.hit_wr ? hit_slot_q : free_q;
	assign ram_wdata = {key_q, (cmd.hit_wr ? hit_wt_q : weight_q), clock_q};

	wlru_ram #(
		.WIDTH(WORD_W),
		.DEPTH(ENTRIES)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(scan_cnt_q[IDX_W-1:0]),
		.rdata(rd_word)
	);

	assign rd_stamp = rd_word[STAMP_W-1:0];
	assign rd_wt    = rd_word[STAMP_W +: WEIGHT_W];
	assign rd_key   = rd_word[STAMP_W + WEIGHT_W +: KEY_W];
	assign slot_vld = valid_q[idx_s1];

	assign sts.match       = cmd.look && v_s1 && slot_vld && (rd_key == key_q);
	assign sts.scan_done   = v_s1 && (idx_s1 == IDX_W'(ENTRIES - 1));
	assign sts.over_budget = total_q > TOTAL_W'(budget_q);
	assign sts.empty       = (count_q == '0);
	assign sts.full        = (count_q == CNT_W'(ENTRIES));
	assign sts.out_free    = out_free;

	// hit capture and oldest-entry search, lowest slot wins on equal stamps
	always_ff @(posedge clk) begin
		if (sts.match) begin
			hit_slot_q <= idx_s1;
			hit_wt_q   <= rd_wt;
		end
		if (cmd.old && v_s1 && slot_vld && (!best_found_q || rd_stamp < best_stamp_q)) begin
			best_q       <= idx_s1;
			best_stamp_q <= rd_stamp;
			best_key_q   <= rd_key;
			best_wt_q    <= rd_wt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q <= 1'b0;
		end else if (cmd.start_old) begin
			best_found_q <= 1'b0;
		end else if (cmd.old && v_s1 && slot_vld) begin
			best_found_q <= 1'b1;
		end
	end

	// lowest free slot: found during lookup, lowered by evictions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_found_q <= 1'b0;
			free_q       <= '0;
		end else if (cmd.load) begin
			free_found_q <= 1'b0;
		end else if (cmd.look && v_s1 && !slot_vld && !free_found_q) begin
			free_found_q <= 1'b1;
			free_q       <= idx_s1;
		end else if (cmd.evict && (!free_found_q || best_q < free_q)) begin
			free_found_q <= 1'b1;
			free_q       <= best_q;
		end
	end

	always_comb begin
		total_nxt = total_q;
		count_nxt = count_q;
		if (cmd.evict) begin
			total_nxt = total_q - TOTAL_W'(best_wt_q);
			count_nxt = count_q - CNT_W'(1);
		end else if (cmd.insert) begin
			total_nxt = total_q + TOTAL_W'(weight_q);
			count_nxt = count_q + CNT_W'(1);
		end
	end

	assign count_ext = EXT_W'(count_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			total_q <= '0;
			count_q <= '0;
			clock_q <= '0;
		end else begin
			total_q <= total_nxt;
			count_q <= count_nxt;
			if (cmd.evict) begin
				valid_q[best_q] <= 1'b0;
			end else if (cmd.insert) begin
				valid_q[free_q] <= 1'b1;
			end
			if (cmd.hit_wr || cmd.insert) begin
				clock_q <= clock_q + STAMP_W'(1);
			end
		end
	end

	// result register
	assign emit     = cmd.hit_wr || cmd.evict || cmd.insert;
	assign out_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_item_q.is_eviction  <= cmd.evict;
			rsp_item_q.evicted_key  <= cmd.evict ? best_key_q : '0;
			rsp_item_q.hit          <= cmd.hit_wr;
			rsp_item_q.total_weight <= total_nxt[TOTAL_OUT_W-1:0];
			rsp_item_q.entry_count  <= count_ext[COUNT_OUT_W-1:0];
			rsp_item_q.last         <= !cmd.evict;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;
endmodule

// ----- hw/rtl/weighted_lru_cache_policy.sv -----
// top level of the weighted lru cache policy block
//
// req channel: one transfer per access, carrying key and pixel weight.
// rsp channel: zero or more eviction results (is_eviction=1, evicted_key set)
// followed by one final result (last=1, hit tells present or inserted).
// every result carries the pixel total and entry count after it.
// config: cfg_wr_en/cfg_index/cfg_wdata write budget_setting (index 0) and
// default_budget (index 1); write only while no access is in flight.
// sequence: the lookup walks the slot table one slot per cycle through the
// slot ram, then a hit writes back its refreshed stamp. a miss adds a budget
// check, per eviction an oldest-entry scan of the same ram port, the eviction
// itself and the next budget check, and then the insert.
// one access is in work at a time; req is ready again as soon as the final
// result sits in the output register.
// reset: all slots invalid, totals and use clock zero, budget from defaults;
// no clearing pass is needed.
// a stalled rsp holds its result; the sequencer waits before each further
// result until the output register frees up.
module weighted_lru_cache_policy import wlru_pkg::*; #(
	parameter int ENTRIES = WLRU_ENTRIES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	wlru_req_if.sink              req,
	wlru_rsp_if.source            rsp
);
	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	// sequencer: walks lookup, eviction loop and insert
	wlru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// slot table, scans, totals and the result register
	wlru_dp #(
		.ENTRIES(ENTRIES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req_item (req.item),
		.rsp_valid(rsp.valid),
		.rsp_item (rsp.item),
		.rsp_ready(rsp.ready),
		.cmd      (cmd),
		.sts      (sts)
	);
endmodule

// ----- hw/rtl/wlru_checker.sv -----
// port-level checks on the cache policy block, bound to the top level
`include "assert_macros.svh"

module wlru_checker import wlru_pkg::*; #(
	parameter int ENTRIES = WLRU_ENTRIES
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_ready,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input logic                   rsp_is_eviction,
	input logic [KEY_W-1:0]       rsp_evicted_key,
	input logic                   rsp_hit,
	input logic [TOTAL_OUT_W-1:0] rsp_total_weight,
	input logic [COUNT_OUT_W-1:0] rsp_entry_count,
	input logic                   rsp_last
);
	`WLRU_ASSERT_IMP(a_count_bound, clk, arst_n, rsp_valid, 32'(rsp_entry_count) <= ENTRIES, "entry count above table size")

	`WLRU_ASSERT_IMP(a_kind, clk, arst_n, rsp_valid, rsp_is_eviction != rsp_last, "eviction and final flags disagree")

	`WLRU_ASSERT_IMP(a_final_fields, clk, arst_n, rsp_valid && rsp_last, rsp_evicted_key == '0, "final result carries an evicted key")

	`WLRU_ASSERT_NXT(a_busy, clk, arst_n, req_valid && req_ready, !req_ready, "request taken while access in work")

	`WLRU_ASSERT_NXT(a_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_total_weight) && $stable(rsp_hit), "stalled result changed")
endmodule

bind weighted_lru_cache_policy wlru_checker #(
	.ENTRIES(ENTRIES)
) u_wlru_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_is_eviction (rsp.item.is_eviction),
	.rsp_evicted_key (rsp.item.evicted_key),
	.rsp_hit         (rsp.item.hit),
	.rsp_total_weight(rsp.item.total_weight),
	.rsp_entry_count (rsp.item.entry_count),
	.rsp_last        (rsp.item.last)
);
